### src/huffman_tree_walk_decoder_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the Huffman tree-walk decoder
// Concurrent checks on clk_i, off while rst_ni is low; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef HUFFMAN_TREE_WALK_DECODER_MACROS_SVH
`define HUFFMAN_TREE_WALK_DECODER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication: ante |-> cons.
`define HTWD_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: ante |=> cons.
`define HTWD_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define HTWD_ASSERT(label, ante, cons, msg)
`define HTWD_ASSERT_NXT(label, ante, cons, msg)

`endif

`endif

### src/htwd_pkg.sv
// ----------------------------------------------------------------------------
// htwd_pkg
// Shared types and constants of the Huffman tree-walk decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package htwd_pkg;

  localparam int NODE_COUNT_DEF = 512;
  localparam int BITS_PER_BYTE  = 8;
  localparam int BITS_W         = $clog2(BITS_PER_BYTE + 1);

  localparam int IDX_W   = 9;
  localparam int SYM_W   = 8;
  localparam int FBITS_W = 3;

  // input stream payload: node_index, child_zero, child_one, node_symbol, code_byte
  localparam int S_FIELDS_W = 3 * IDX_W + 2 * SYM_W;
  localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
  localparam int M_TDATA_W  = SYM_W;

  localparam logic [SYM_W-1:0] SYM_INNER = '0;
  localparam logic [SYM_W-1:0] SYM_FLAG  = '1;

  localparam logic [0:0] REG_FINAL_BITS = 1'b0;

  typedef enum logic {
    OP_NODE = 1'b0,
    OP_CODE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_MISSING = 2'd1,
    STATUS_SYM255  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FLUSH
  } walk_state_e;

  typedef struct packed {
    logic [IDX_W-1:0] child_one;
    logic [IDX_W-1:0] child_zero;
    logic [SYM_W-1:0] symbol;
  } node_t;

  // walker to output stage: one committed result or the end of a byte
  typedef struct packed {
    logic             push;
    logic             flush;
    logic [SYM_W-1:0] symbol;
    status_e          status;
  } res_req_t;

endpackage

`default_nettype wire

### src/htwd_node_mem.sv
// ----------------------------------------------------------------------------
// htwd_node_mem
// Node table: one write port, one registered read port, root shadow copy.
// ----------------------------------------------------------------------------
`default_nettype none

module htwd_node_mem import htwd_pkg::*; #(
  parameter int NODE_COUNT = NODE_COUNT_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             wr_en_i,
  input  wire logic [IDX_W-1:0] wr_idx_i,
  input  wire node_t            wr_node_i,
  input  wire logic             rd_en_i,
  input  wire logic [IDX_W-1:0] rd_idx_i,
  output node_t                 rd_node_o,
  output node_t                 root_o
);

  localparam int AW = $clog2(NODE_COUNT);

  node_t          mem_q [NODE_COUNT];
  node_t          rd_node_q;
  node_t          root_q;
  logic [31:0]    wr_ext;
  logic [31:0]    rd_ext;
  logic [AW-1:0]  wr_addr;
  logic [AW-1:0]  rd_addr;
  logic           wr_in_range;

  assign wr_ext      = 32'(wr_idx_i);
  assign rd_ext      = 32'(rd_idx_i);
  assign wr_addr     = wr_ext[AW-1:0];
  assign rd_addr     = rd_ext[AW-1:0];
  assign wr_in_range = wr_ext < 32'(NODE_COUNT);

  always_ff @(posedge clk_i) begin
    if (wr_en_i && wr_in_range) begin
      mem_q[wr_addr] <= wr_node_i;
    end
    if (rd_en_i) begin
      rd_node_q <= mem_q[rd_addr];
    end
  end

  // keep the root at hand so a return to the root costs no read
  always_ff @(posedge clk_i) begin
    if (wr_en_i && (wr_idx_i == '0)) begin
      root_q <= wr_node_i;
    end
  end

  assign rd_node_o = rd_node_q;
  assign root_o    = root_q;

endmodule

`default_nettype wire

### src/htwd_walker.sv
// ----------------------------------------------------------------------------
// htwd_walker
// Takes items, walks the tree on code bits MSB first, at most one bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "huffman_tree_walk_decoder_macros.svh"

module htwd_walker import htwd_pkg::*; #(
  parameter int NODE_COUNT = NODE_COUNT_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               item_valid_i,
  output logic                    item_ready_o,
  input  wire logic               op_i,
  input  wire logic [IDX_W-1:0]   node_index_i,
  input  wire logic [IDX_W-1:0]   child_zero_i,
  input  wire logic [IDX_W-1:0]   child_one_i,
  input  wire logic [SYM_W-1:0]   node_symbol_i,
  input  wire logic [SYM_W-1:0]   code_byte_i,
  input  wire logic               final_byte_i,
  input  wire logic [FBITS_W-1:0] final_bits_i,
  output logic                    wr_en_o,
  output logic [IDX_W-1:0]        wr_idx_o,
  output node_t                   wr_node_o,
  output logic                    rd_en_o,
  output logic [IDX_W-1:0]        rd_idx_o,
  input  wire node_t              rd_node_i,
  input  wire node_t              root_i,
  output res_req_t                req_o,
  input  wire logic               res_rdy_i
);

  walk_state_e              state_q, state_d;
  logic [BITS_PER_BYTE-1:0] sr_q, sr_d;
  logic [BITS_W-1:0]        bits_q, bits_d;
  logic                     final_q, final_d;
  logic [IDX_W-1:0]         cur_q, cur_d;
  logic                     src_mem_q, src_mem_d;
  logic                     chk_sym_q, chk_sym_d;

  logic                     hit_sym;
  node_t                    kids;
  logic [IDX_W-1:0]         nxt;
  logic                     nxt_ok;
  logic                     bit_pend;

  // a node fetched on the previous bit may be a leaf
  assign hit_sym  = src_mem_q && chk_sym_q && (rd_node_i.symbol != SYM_INNER);
  assign kids     = (src_mem_q && !hit_sym) ? rd_node_i : root_i;
  assign nxt      = sr_q[BITS_PER_BYTE-1] ? kids.child_one : kids.child_zero;
  assign nxt_ok   = (nxt != '0) && (32'(nxt) < 32'(NODE_COUNT));
  assign bit_pend = bits_q != '0;

  assign wr_idx_o  = node_index_i;
  assign wr_node_o = '{child_one: child_one_i, child_zero: child_zero_i,
                       symbol: node_symbol_i};

  always_comb begin
    state_d      = state_q;
    sr_d         = sr_q;
    bits_d       = bits_q;
    final_d      = final_q;
    cur_d        = cur_q;
    src_mem_d    = src_mem_q;
    chk_sym_d    = chk_sym_q;
    item_ready_o = 1'b0;
    wr_en_o      = 1'b0;
    rd_en_o      = 1'b0;
    rd_idx_o     = cur_q;
    req_o        = '{push: 1'b0, flush: 1'b0, symbol: SYM_INNER, status: STATUS_OK};

    case (state_q)
      ST_IDLE: begin
        item_ready_o = 1'b1;
        if (item_valid_i) begin
          if (op_i == OP_NODE) begin
            wr_en_o = 1'b1;
          end else begin
            sr_d    = code_byte_i;
            final_d = final_byte_i;
            if (final_byte_i && (final_bits_i != '0)) begin
              bits_d = BITS_W'(final_bits_i);
            end else begin
              bits_d = BITS_W'(BITS_PER_BYTE);
            end
            // re-read a non-root current node: it may have been rewritten
            if (cur_q != '0) begin
              rd_en_o   = 1'b1;
              src_mem_d = 1'b1;
              chk_sym_d = 1'b0;
            end else begin
              src_mem_d = 1'b0;
            end
            state_d = ST_WALK;
          end
        end
      end

      ST_WALK: begin
        if (hit_sym) begin
          req_o.push   = res_rdy_i;
          req_o.symbol = rd_node_i.symbol;
          req_o.status = (rd_node_i.symbol == SYM_FLAG) ? STATUS_SYM255 : STATUS_OK;
          if (res_rdy_i) begin
            cur_d     = '0;
            src_mem_d = 1'b0;
            // a missing child from the root is left for a later result of its own
            if (bit_pend && nxt_ok) begin
              sr_d      = {sr_q[BITS_PER_BYTE-2:0], 1'b0};
              bits_d    = bits_q - BITS_W'(1);
              rd_en_o   = 1'b1;
              rd_idx_o  = nxt;
              cur_d     = nxt;
              src_mem_d = 1'b1;
              chk_sym_d = 1'b1;
            end
          end
        end else if (!bit_pend) begin
          state_d = ST_FLUSH;
        end else if (!nxt_ok) begin
          req_o.push   = res_rdy_i;
          req_o.symbol = SYM_INNER;
          req_o.status = STATUS_MISSING;
          if (res_rdy_i) begin
            sr_d      = {sr_q[BITS_PER_BYTE-2:0], 1'b0};
            bits_d    = bits_q - BITS_W'(1);
            cur_d     = '0;
            src_mem_d = 1'b0;
          end
        end else begin
          sr_d      = {sr_q[BITS_PER_BYTE-2:0], 1'b0};
          bits_d    = bits_q - BITS_W'(1);
          rd_en_o   = 1'b1;
          rd_idx_o  = nxt;
          cur_d     = nxt;
          src_mem_d = 1'b1;
          chk_sym_d = 1'b1;
        end
      end

      ST_FLUSH: begin
        req_o.flush = res_rdy_i;
        if (res_rdy_i) begin
          if (final_q) begin
            cur_d = '0;
          end
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      bits_q    <= '0;
      final_q   <= 1'b0;
      cur_q     <= '0;
      src_mem_q <= 1'b0;
      chk_sym_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      bits_q    <= bits_d;
      final_q   <= final_d;
      cur_q     <= cur_d;
      src_mem_q <= src_mem_d;
      chk_sym_q <= chk_sym_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sr_q <= sr_d;
  end

  `HTWD_ASSERT(a_idle_no_bits, state_q == ST_IDLE, bits_q == '0, "bits left while idle")
  `HTWD_ASSERT(a_rd_not_root, rd_en_o, rd_idx_o != '0, "table read of the root entry")
  `HTWD_ASSERT(a_no_rd_after_last, (state_q == ST_WALK) && !bit_pend, !rd_en_o,
               "table read after the last bit")

endmodule

`default_nettype wire

### src/htwd_out.sv
// ----------------------------------------------------------------------------
// htwd_out
// Holds back one result until the next shows whether it ends the byte.
// ----------------------------------------------------------------------------
`default_nettype none

`include "huffman_tree_walk_decoder_macros.svh"

module htwd_out import htwd_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire res_req_t     req_i,
  output logic              res_rdy_o,
  output logic              m_valid_o,
  input  wire logic         m_ready_i,
  output logic [SYM_W-1:0]  m_symbol_o,
  output status_e           m_status_o,
  output logic              m_last_o
);

  logic             pend_valid_q, pend_valid_d;
  logic [SYM_W-1:0] pend_sym_q;
  status_e          pend_st_q;
  logic             out_valid_q, out_valid_d;
  logic [SYM_W-1:0] out_sym_q;
  status_e          out_st_q;
  logic             out_last_q;
  logic             out_free;
  logic             load_out;

  assign out_free  = !out_valid_q || m_ready_i;
  assign res_rdy_o = !pend_valid_q || out_free;
  assign load_out  = (req_i.push || req_i.flush) && pend_valid_q;

  always_comb begin
    pend_valid_d = pend_valid_q;
    if (req_i.push) begin
      pend_valid_d = 1'b1;
    end else if (req_i.flush) begin
      pend_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (m_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_sym_q  <= pend_sym_q;
      out_st_q   <= pend_st_q;
      out_last_q <= req_i.flush;
    end
    if (req_i.push) begin
      pend_sym_q <= req_i.symbol;
      pend_st_q  <= req_i.status;
    end
  end

  assign m_valid_o  = out_valid_q;
  assign m_symbol_o = out_sym_q;
  assign m_status_o = out_st_q;
  assign m_last_o   = out_last_q;

  `HTWD_ASSERT(a_push_xor_flush, req_i.push, !req_i.flush, "push and flush together")
  `HTWD_ASSERT(a_no_overwrite, load_out, out_free, "output register overwritten")
  `HTWD_ASSERT_NXT(a_flush_empties, req_i.flush, !pend_valid_q, "result held after flush")

endmodule

`default_nettype wire

### src/huffman_tree_walk_decoder.sv
// ----------------------------------------------------------------------------
// huffman_tree_walk_decoder
// Bit-serial Huffman decoder on a node table, at most one code bit per cycle.
// ----------------------------------------------------------------------------
//
//  Port group   Dir   Contents
//  s_axis_*     in    node writes (tuser = 0) and code bytes (tuser = 1)
//  m_axis_*     out   decoded symbols, status in tuser, tlast ends a byte
//  APB          in    final_bits register at byte address 0
//
//  A node write is done in its accept cycle. A code byte is accepted, walked
//  bit by bit and closed after the last bit; a symbol that is directly
//  followed by a missing child or completed by the last bit is pushed on its
//  own, before the walk goes on. The bound is the node table: every bit
//  needs the entry fetched by the previous bit through its single registered
//  read port.
//  Reset clears the walk state and final_bits; the node table holds garbage
//  until written. The walk waits at a result the output cannot take; new items
//  are taken while a byte's last result still waits in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module huffman_tree_walk_decoder import htwd_pkg::*; #(
  parameter int NODE_COUNT = NODE_COUNT_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // slave stream
  input  wire logic                 s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  // [8:0] node_index, [17:9] child_zero, [26:18] child_one,
  // [34:27] node_symbol, [42:35] code_byte, [47:43] zero
  input  wire logic [S_TDATA_W-1:0] s_axis_tdata_i,
  // [0] op
  input  wire logic [0:0]           s_axis_tuser_i,
  input  wire logic                 s_axis_tlast_i,   // final_byte
  // master stream
  output logic                      m_axis_tvalid_o,
  input  wire logic                 m_axis_tready_i,
  // [7:0] symbol
  output logic [M_TDATA_W-1:0]      m_axis_tdata_o,
  // [1:0] status
  output logic [1:0]                m_axis_tuser_o,
  output logic                      m_axis_tlast_o,   // run_last
  // configuration
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [2:0]           paddr,
  input  wire logic [31:0]          pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  logic [FBITS_W-1:0] final_bits_q;
  logic               reg_hit;

  logic               wr_en;
  logic [IDX_W-1:0]   wr_idx;
  node_t              wr_node;
  logic               rd_en;
  logic [IDX_W-1:0]   rd_idx;
  node_t              rd_node;
  node_t              root_node;
  res_req_t           req;
  logic               res_rdy;
  status_e            m_status;

  // register file: a single register, decoded on the word address
  assign pready  = 1'b1;
  assign reg_hit = paddr[2] == REG_FINAL_BITS;
  assign prdata  = reg_hit ? 32'(final_bits_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      final_bits_q <= '0;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      final_bits_q <= pwdata[FBITS_W-1:0];
    end
  end

  htwd_walker #(
    .NODE_COUNT (NODE_COUNT)
  ) u_walker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_valid_i  (s_axis_tvalid_i),
    .item_ready_o  (s_axis_tready_o),
    .op_i          (s_axis_tuser_i[0]),
    .node_index_i  (s_axis_tdata_i[IDX_W-1:0]),
    .child_zero_i  (s_axis_tdata_i[2*IDX_W-1:IDX_W]),
    .child_one_i   (s_axis_tdata_i[3*IDX_W-1:2*IDX_W]),
    .node_symbol_i (s_axis_tdata_i[3*IDX_W+SYM_W-1:3*IDX_W]),
    .code_byte_i   (s_axis_tdata_i[3*IDX_W+2*SYM_W-1:3*IDX_W+SYM_W]),
    .final_byte_i  (s_axis_tlast_i),
    .final_bits_i  (final_bits_q),
    .wr_en_o       (wr_en),
    .wr_idx_o      (wr_idx),
    .wr_node_o     (wr_node),
    .rd_en_o       (rd_en),
    .rd_idx_o      (rd_idx),
    .rd_node_i     (rd_node),
    .root_i        (root_node),
    .req_o         (req),
    .res_rdy_i     (res_rdy)
  );

  htwd_node_mem #(
    .NODE_COUNT (NODE_COUNT)
  ) u_node_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_idx_i  (wr_idx),
    .wr_node_i (wr_node),
    .rd_en_i   (rd_en),
    .rd_idx_i  (rd_idx),
    .rd_node_o (rd_node),
    .root_o    (root_node)
  );

  // hold one result back so tlast can mark the byte's final one
  htwd_out u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req),
    .res_rdy_o  (res_rdy),
    .m_valid_o  (m_axis_tvalid_o),
    .m_ready_i  (m_axis_tready_i),
    .m_symbol_o (m_axis_tdata_o),
    .m_status_o (m_status),
    .m_last_o   (m_axis_tlast_o)
  );

  assign m_axis_tuser_o = m_status;

endmodule

`default_nettype wire

### test/huffman_tree_walk_decoder_test.sv
// ----------------------------------------------------------------------------
// Huffman tree-walk decoder testbench
// Loads node tables over the input stream, feeds code bytes and checks every
// decoded symbol, its status and its end-of-byte flag against a local walk of
// the same table, under random idling on both streams and several
// final_bits settings.
// ----------------------------------------------------------------------------

class symbol_scoreboard;

  typedef struct packed {
    logic [htwd_pkg::SYM_W-1:0] symbol;
    htwd_pkg::status_e          status;
    logic                       run_last;
  } symbol_t;

  htwd_pkg::node_t              tree[htwd_pkg::NODE_COUNT_DEF];
  logic [htwd_pkg::IDX_W-1:0]   walk_node;
  logic [htwd_pkg::FBITS_W-1:0] final_bits;
  symbol_t                      due[$];
  int unsigned                  errors;
  int unsigned                  checked;

  function new();
    foreach (tree[i]) tree[i] = '0;
    walk_node  = '0;
    final_bits = '0;
    errors     = 0;
    checked    = 0;
  endfunction

  function int unsigned pending();
    return due.size();
  endfunction

  function void set_final_bits(logic [htwd_pkg::FBITS_W-1:0] value);
    final_bits = value;
  endfunction

  // Walk one accepted item through the local node table.
  function void note_item(htwd_pkg::op_e op, logic [htwd_pkg::S_TDATA_W-1:0] data,
                          logic last);
    logic [htwd_pkg::IDX_W-1:0] idx;
    logic [htwd_pkg::IDX_W-1:0] cur;
    logic [htwd_pkg::IDX_W-1:0] nxt;
    logic [htwd_pkg::SYM_W-1:0] code;
    htwd_pkg::node_t            entry;
    symbol_t                    res;
    int                         nbits;
    int unsigned                first;

    idx = data[8:0];
    if (op == htwd_pkg::OP_NODE) begin
      if (idx < htwd_pkg::NODE_COUNT_DEF) begin
        entry.child_zero = data[17:9];
        entry.child_one  = data[26:18];
        entry.symbol     = data[34:27];
        tree[idx] = entry;
      end
      return;
    end

    code  = data[42:35];
    nbits = (last && final_bits != 0) ? int'(final_bits) : htwd_pkg::BITS_PER_BYTE;
    first = due.size();
    for (int b = 0; b < nbits; b++) begin
      cur = (walk_node < htwd_pkg::NODE_COUNT_DEF) ? walk_node : '0;
      nxt = code[htwd_pkg::BITS_PER_BYTE-1-b] ? tree[cur].child_one : tree[cur].child_zero;
      res.run_last = 1'b0;
      if (nxt == 0 || nxt >= htwd_pkg::NODE_COUNT_DEF) begin
        res.symbol = '0;
        res.status = htwd_pkg::STATUS_MISSING;
        due.push_back(res);
        walk_node = '0;
      end else if (tree[nxt].symbol != htwd_pkg::SYM_INNER) begin
        res.symbol = tree[nxt].symbol;
        res.status = (tree[nxt].symbol == htwd_pkg::SYM_FLAG) ? htwd_pkg::STATUS_SYM255
                                                                : htwd_pkg::STATUS_OK;
        due.push_back(res);
        walk_node = '0;
      end else begin
        walk_node = nxt;
      end
    end
    if (last) walk_node = '0;
    if (due.size() > first) due[due.size()-1].run_last = 1'b1;
  endfunction

  task report(string what);
    errors++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  task check_result(logic [htwd_pkg::SYM_W-1:0] symbol, logic [1:0] status, logic last);
    symbol_t want;
    if (due.size() == 0) begin
      report($sformatf("unexpected symbol %02h status %0d", symbol, status));
      return;
    end
    want = due.pop_front();
    checked++;
    if (symbol !== want.symbol)
      report($sformatf("symbol %02h, want %02h", symbol, want.symbol));
    if (status !== want.status)
      report($sformatf("status %0d, want %0d", status, want.status));
    if (last !== want.run_last)
      report($sformatf("run_last %0b, want %0b", last, want.run_last));
  endtask

endclass

module huffman_tree_walk_decoder_test;
  timeunit 1ns;
  timeprecision 1ps;

  import htwd_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int ITEM_TARGET  = 210;
  localparam int HOLD_CYCLES  = 250;     // long output hold-off, fills the block
  localparam int DRAIN_CYCLES = 16;
  localparam int TAIL_CYCLES  = 64;
  localparam int LIMIT_NS     = 3_000_000;

  logic                 clk_i  = 1'b0;
  logic                 rst_ni = 1'b0;

  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
  logic [0:0]           s_axis_tuser  = OP_NODE;
  logic                 s_axis_tlast  = 1'b0;

  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b1;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic [1:0]           m_axis_tuser;
  logic                 m_axis_tlast;

  logic                 psel    = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite  = 1'b0;
  logic [2:0]           paddr   = '0;
  logic [31:0]          pwdata  = '0;
  logic [31:0]          prdata;
  logic                 pready;

  symbol_scoreboard     sb = new();

  // Stimulus knobs shared with the output side.
  bit                   gaps_on   = 1'b1;
  bit                   stalls_on = 1'b1;
  bit                   hold_now  = 1'b0;

  // Node entries written so far; only these may be named as children.
  bit                   built[NODE_COUNT_DEF];
  logic [IDX_W-1:0]     built_list[$];
  bit                   taken[NODE_COUNT_DEF];

  int unsigned          item_count = 0;
  int unsigned          node_count = 0;
  int unsigned          byte_count = 0;
  int unsigned          holds_done = 0;
  bit                   fb_seen[8];

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  huffman_tree_walk_decoder dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .s_axis_tlast_i  (s_axis_tlast),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tuser_o  (m_axis_tuser),
    .m_axis_tlast_o  (m_axis_tlast),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  // Check every result taken at a clock edge, sampled before the edge updates.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
  end

  // Output side: short random stalls, plus one long hold-off on request.
  initial begin : output_side
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_now) begin
        hold_now = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        m_axis_tready <= 1'b1;
        holds_done++;
      end else if (stalls_on && $urandom_range(0, 7) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Offer one item, optionally after an idle burst, and hold it until taken.
  task automatic push_item(input op_e op, input logic [S_TDATA_W-1:0] data,
                           input logic last);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tuser  <= op;
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_item(op, data, last);
    item_count++;
  endtask

  // Node write; the code byte field and tlast carry noise.
  task automatic push_node(input logic [IDX_W-1:0] idx, input logic [IDX_W-1:0] zero,
                           input logic [IDX_W-1:0] one, input logic [SYM_W-1:0] sym);
    push_item(OP_NODE, {5'b0, 8'($urandom), sym, one, zero, idx}, 1'($urandom));
    if (!built[idx]) begin
      built[idx] = 1'b1;
      built_list.push_back(idx);
    end
    node_count++;
  endtask

  // Code byte; the node fields carry noise.
  task automatic push_code(input logic [SYM_W-1:0] code, input logic last);
    push_item(OP_CODE, {5'b0, code, 8'($urandom), 9'($urandom), 9'($urandom),
                        9'($urandom)}, last);
    byte_count++;
  endtask

  // Drop valid and wait until the block has nothing left in flight.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Write final_bits over APB, then read it back.
  task automatic write_final_bits(input logic [FBITS_W-1:0] value);
    logic [31:0] back;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_FINAL_BITS, 2'b00};
    pwdata  <= 32'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    sb.set_final_bits(value);
    fb_seen[value] = 1'b1;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    back = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (back !== 32'(value))
      sb.report($sformatf("final_bits reads %0h, want %0h", back, value));
  endtask

  function automatic logic [IDX_W-1:0] fresh_index();
    logic [IDX_W-1:0] idx;
    do idx = IDX_W'($urandom_range(1, NODE_COUNT_DEF - 1)); while (taken[idx]);
    taken[idx] = 1'b1;
    return idx;
  endfunction

  // No child a quarter of the time, else some entry already written.
  function automatic logic [IDX_W-1:0] any_child();
    if ($urandom_range(0, 3) == 0) return '0;
    return built_list[$urandom_range(0, built_list.size() - 1)];
  endfunction

  function automatic logic [SYM_W-1:0] leaf_symbol();
    if ($urandom_range(0, 7) == 0) return SYM_FLAG;
    return SYM_W'($urandom_range(1, 255));
  endfunction

  // Build a random tree bottom up so every child is written before use;
  // the root goes last.
  task automatic grow_tree(input int leaves);
    logic [IDX_W-1:0] pool[$];
    logic [IDX_W-1:0] a;
    logic [IDX_W-1:0] b;
    logic [IDX_W-1:0] n;
    int               pos;

    foreach (taken[i]) taken[i] = 1'b0;
    repeat (leaves) begin
      n = fresh_index();
      push_node(n, any_child(), any_child(), leaf_symbol());
      pool.push_back(n);
    end
    while (pool.size() > 2) begin
      pos = $urandom_range(0, pool.size() - 1);
      a = pool[pos];
      pool.delete(pos);
      pos = $urandom_range(0, pool.size() - 1);
      b = pool[pos];
      pool.delete(pos);
      // now and then leave one side open and put that subtree back
      if ($urandom_range(0, 7) == 0) begin
        pool.push_back(b);
        b = '0;
      end
      n = fresh_index();
      if ($urandom_range(0, 1) == 0) push_node(n, a, b, SYM_INNER);
      else push_node(n, b, a, SYM_INNER);
      pool.push_back(n);
    end
    if ($urandom_range(0, 1) == 0) push_node('0, pool[0], pool[1], SYM_INNER);
    else push_node('0, pool[1], pool[0], SYM_INNER);
  endtask

  // Directed part: a small fixed tree with a leaf, a 255 leaf, a missing
  // child and a self loop that swallows a run of ones.
  //   0 -> symbol 01, 10 -> missing, 11 1* 0 -> symbol FF
  task automatic directed();
    write_final_bits(3'd0);
    push_node(9'd5,   9'd0,   9'd0,   8'h01);
    push_node(9'd6,   9'd0,   9'd0,   SYM_FLAG);
    push_node(9'd301, 9'd6,   9'd301, SYM_INNER);
    push_node(9'd300, 9'd0,   9'd301, SYM_INNER);
    push_node(9'd511, 9'd511, 9'd511, 8'hFE);
    push_node(9'd0,   9'd5,   9'd300, SYM_INNER);

    push_code(8'h00, 1'b0);   // eight results from one byte
    push_code(8'hFF, 1'b0);   // parks in the loop, no result
    push_code(8'h00, 1'b0);   // 255 leaf, then seven more
    push_code(8'h80, 1'b0);   // missing child first
    push_code(8'hBF, 1'b0);   // missing child, then an open walk
    push_code(8'h7F, 1'b1);   // final byte, all eight bits, open walk dropped
    push_code(8'h00, 1'b0);   // starts again from the root

    settle();
    write_final_bits(3'd3);
    push_code(8'h5F, 1'b1);   // three bits: a symbol and a missing child
    push_code(8'hC0, 1'b1);   // three bits reach the 255 leaf
    push_code(8'hE0, 1'b1);   // three bits complete nothing
    push_code(8'h00, 1'b0);   // not final: all eight bits count

    settle();
    write_final_bits(3'd7);
    push_code(8'h01, 1'b1);   // last bit cut off
    push_code(8'hFE, 1'b1);
    push_code(8'h00, 1'b1);
  endtask

  initial begin : stimulus
    int               phase;
    int unsigned      fb_count;
    logic [FBITS_W-1:0] fb;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed();

    // Random phases: a fresh tree per phase, then code bytes with stray
    // node writes mixed in.
    phase = 0;
    while (item_count < ITEM_TARGET) begin
      case (phase)
        0:       fb = 3'd7;
        1:       fb = 3'd1;
        2:       fb = 3'd0;
        default: fb = FBITS_W'($urandom);
      endcase
      settle();
      write_final_bits(fb);
      // quiet tail: no idling on either side
      if (item_count + 40 >= ITEM_TARGET) begin
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
      end
      grow_tree($urandom_range(2, 9));
      if (phase == 1) hold_now = 1'b1;
      repeat (24) begin
        if ($urandom_range(0, 11) == 0)
          push_node(IDX_W'($urandom), any_child(), any_child(), SYM_W'($urandom));
        else
          push_code(SYM_W'($urandom), $urandom_range(0, 5) == 0);
      end
      phase++;
    end

    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    fb_count = 0;
    foreach (fb_seen[i]) fb_count += fb_seen[i];
    $display("covered %0d node writes and %0d code bytes over %0d final_bits values",
             node_count, byte_count, fb_count);
    $display("checked %0d decoded symbols, %0d long output hold-off(s)",
             sb.checked, holds_done);
    if (sb.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin : watchdog
    #(LIMIT_NS);
    $display("end of test: mismatches");
    $finish;
  end

endmodule
